>>> design/sha256_stream_hasher_macros.svh
// Assertion macros shared by the hasher RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef SHA256_STREAM_HASHER_MACROS_SVH
`define SHA256_STREAM_HASHER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on the rising edge, off during reset.
`define SHS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("shs: same-cycle check failed");

// Next-cycle implication, sampled on the rising edge, off during reset.
`define SHS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("shs: next-cycle check failed");

`else

`define SHS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SHS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> design/shs_pkg.sv
// Shared types, constants and round functions of the SHA-256 stream hasher.
// No dependencies; imported by shs_ctrl, shs_datapath and the top level.
package shs_pkg;

    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned CNT_W       = 6;
    localparam int unsigned ROUNDS      = 64;
    localparam int unsigned RND_W       = 6;
    localparam int unsigned HASH_WORDS  = 8;
    localparam int unsigned WIDX_W      = 3;
    localparam int unsigned LEN_POS     = 56;
    localparam int unsigned BLK_W       = BLOCK_BYTES * 8;

    localparam logic [CNT_W-1:0]  LAST_BYTE  = CNT_W'(BLOCK_BYTES - 1);
    localparam logic [CNT_W-1:0]  PRE_LEN    = CNT_W'(LEN_POS - 1);
    localparam logic [RND_W-1:0]  LAST_ROUND = RND_W'(ROUNDS - 1);
    localparam logic [WIDX_W-1:0] WORD_LAST  = WIDX_W'(HASH_WORDS - 1);
    localparam logic [7:0]        PAD_MARK   = 8'h80;
    localparam logic [63:0]       BITS_PER_BYTE = 64'd8;

    localparam logic [31:0] HASH_IV [HASH_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] K_TABLE [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef enum logic {
        ACT_ABSORB = 1'b0,
        ACT_FINISH = 1'b1
    } shs_action_t;

    typedef struct packed {
        logic       action;
        logic [7:0] msg_byte;
    } shs_in_t;

    typedef struct packed {
        logic [31:0]       digest_word;
        logic [WIDX_W-1:0] word_index;
        logic              last_word;
    } shs_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_ROUND,
        ST_FINAL,
        ST_EMIT
    } shs_state_t;

    typedef enum logic [1:0] {
        BSEL_INPUT,
        BSEL_MARK,
        BSEL_ZERO,
        BSEL_LEN
    } shs_bsel_t;

    typedef struct packed {
        logic              shift_byte;
        shs_bsel_t         byte_sel;
        logic              count_bits;
        logic              load_vars;
        logic              round;
        logic [RND_W-1:0]  rnd;
        logic              fold;
        logic              emit;
        logic [WIDX_W-1:0] word_idx;
        logic              restart;
    } shs_cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic             out_free;
    } shs_sts_t;

    function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
        return (v >> n) | (v << (32 - n));
    endfunction

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sig0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sig1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

>>> design/shs_ctrl.sv
// Sequencer of the SHA-256 stream hasher: absorb, padding, rounds, digest emission.
// Depends on shs_pkg and sha256_stream_hasher_macros.svh; drives shs_datapath.
`include "sha256_stream_hasher_macros.svh"

module shs_ctrl
    import shs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     msg_valid,
    output logic     msg_ready,
    input  logic     action,
    input  shs_sts_t sts,
    output shs_cmd_t cmd
);

    shs_state_t        state_reg, state_next;
    shs_state_t        ret_reg, ret_next;
    logic [RND_W-1:0]  rnd_reg, rnd_next;
    logic [WIDX_W-1:0] widx_reg, widx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            rnd_reg   <= '0;
            widx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            rnd_reg   <= rnd_next;
            widx_reg  <= widx_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        rnd_next     = rnd_reg;
        widx_next    = widx_reg;
        msg_ready    = 1'b0;
        cmd          = '0;
        cmd.byte_sel = BSEL_INPUT;
        cmd.rnd      = rnd_reg;
        cmd.word_idx = widx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                msg_ready = 1'b1;
                if (msg_valid)
                begin
                    if (action == ACT_ABSORB)
                    begin
                        cmd.shift_byte = 1'b1;
                        cmd.count_bits = 1'b1;
                        if (sts.cnt == LAST_BYTE)
                        begin
                            cmd.load_vars = 1'b1;
                            rnd_next      = '0;
                            ret_next      = ST_IDLE;
                            state_next    = ST_ROUND;
                        end
                    end
                    else
                    begin
                        state_next = ST_PAD_MARK;
                    end
                end
            end

            ST_PAD_MARK:
            begin
                cmd.shift_byte = 1'b1;
                cmd.byte_sel   = BSEL_MARK;
                if (sts.cnt == LAST_BYTE)
                begin
                    // marker filled the block: length goes in an extra block
                    cmd.load_vars = 1'b1;
                    rnd_next      = '0;
                    ret_next      = ST_PAD_ZERO;
                    state_next    = ST_ROUND;
                end
                else if (sts.cnt == PRE_LEN)
                begin
                    state_next = ST_PAD_LEN;
                end
                else
                begin
                    state_next = ST_PAD_ZERO;
                end
            end

            ST_PAD_ZERO:
            begin
                cmd.shift_byte = 1'b1;
                cmd.byte_sel   = BSEL_ZERO;
                if (sts.cnt == LAST_BYTE)
                begin
                    cmd.load_vars = 1'b1;
                    rnd_next      = '0;
                    ret_next      = ST_PAD_ZERO;
                    state_next    = ST_ROUND;
                end
                else if (sts.cnt == PRE_LEN)
                begin
                    state_next = ST_PAD_LEN;
                end
            end

            ST_PAD_LEN:
            begin
                cmd.shift_byte = 1'b1;
                cmd.byte_sel   = BSEL_LEN;
                if (sts.cnt == LAST_BYTE)
                begin
                    cmd.load_vars = 1'b1;
                    rnd_next      = '0;
                    widx_next     = '0;
                    ret_next      = ST_EMIT;
                    state_next    = ST_ROUND;
                end
            end

            ST_ROUND:
            begin
                cmd.round = 1'b1;
                rnd_next  = rnd_reg + 1'b1;
                if (rnd_reg == LAST_ROUND)
                begin
                    state_next = ST_FINAL;
                end
            end

            ST_FINAL:
            begin
                cmd.fold   = 1'b1;
                state_next = ret_reg;
            end

            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit  = 1'b1;
                    widx_next = widx_reg + 1'b1;
                    if (widx_reg == WORD_LAST)
                    begin
                        cmd.restart = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `SHS_ASSERT_NXT(a_round_entry_clear, clk, rst_n, state_reg != ST_ROUND && state_next == ST_ROUND, rnd_reg == '0)
    `SHS_ASSERT_NXT(a_round_to_final, clk, rst_n, state_reg == ST_ROUND && rnd_reg == LAST_ROUND, state_reg == ST_FINAL)
    `SHS_ASSERT_IMP(a_round_block_aligned, clk, rst_n, state_reg == ST_ROUND, sts.cnt == '0)
    `SHS_ASSERT_NXT(a_emit_done, clk, rst_n, cmd.emit && widx_reg == WORD_LAST, state_reg == ST_IDLE && widx_reg == '0)

endmodule

>>> design/shs_datapath.sv
// Datapath of the SHA-256 stream hasher: block shift line, schedule, round logic,
// hash words, bit counter and the registered digest output. Depends on shs_pkg.
module shs_datapath
    import shs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] msg_byte,
    input  shs_cmd_t   cmd,
    output shs_sts_t   sts,
    output logic       dig_valid,
    input  logic       dig_ready,
    output shs_out_t   dig
);

    // block buffer doubles as the 16-word schedule window, word 0 at the top
    logic [BLK_W-1:0] blk_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [63:0]      bitcnt_reg;
    logic [31:0]      hash_reg [HASH_WORDS];
    logic [31:0]      wv_reg [HASH_WORDS];
    logic             out_valid_reg;
    shs_out_t         out_reg;

    logic [7:0]  byte_in;
    logic [31:0] w0, w1, w9, w14, w_new;
    logic [31:0] t1, t2;
    logic [31:0] e_ch, a_maj;

    always_comb
    begin
        unique case (cmd.byte_sel)
            BSEL_INPUT: byte_in = msg_byte;
            BSEL_MARK:  byte_in = PAD_MARK;
            BSEL_ZERO:  byte_in = 8'h00;
            BSEL_LEN:   byte_in = bitcnt_reg[{~cnt_reg[2:0], 3'b000} +: 8];
        endcase
    end

    assign w0  = blk_reg[BLK_W-1    -: 32];
    assign w1  = blk_reg[BLK_W-33   -: 32];
    assign w9  = blk_reg[BLK_W-289  -: 32];
    assign w14 = blk_reg[BLK_W-449  -: 32];
    assign w_new = small_sig1(w14) + w9 + small_sig0(w1) + w0;

    assign e_ch  = (wv_reg[4] & wv_reg[5]) ^ (~wv_reg[4] & wv_reg[6]);
    assign a_maj = (wv_reg[0] & wv_reg[1]) ^ (wv_reg[0] & wv_reg[2]) ^ (wv_reg[1] & wv_reg[2]);
    assign t1 = wv_reg[7] + big_sig1(wv_reg[4]) + e_ch + K_TABLE[cmd.rnd] + w0;
    assign t2 = big_sig0(wv_reg[0]) + a_maj;

    always_ff @(posedge clk)
    begin
        if (cmd.shift_byte)
        begin
            blk_reg <= {blk_reg[BLK_W-9:0], byte_in};
        end
        else if (cmd.round)
        begin
            blk_reg <= {blk_reg[BLK_W-33:0], w_new};
        end

        if (cmd.load_vars)
        begin
            for (int i = 0; i < HASH_WORDS; i++)
            begin
                wv_reg[i] <= hash_reg[i];
            end
        end
        else if (cmd.round)
        begin
            wv_reg[7] <= wv_reg[6];
            wv_reg[6] <= wv_reg[5];
            wv_reg[5] <= wv_reg[4];
            wv_reg[4] <= wv_reg[3] + t1;
            wv_reg[3] <= wv_reg[2];
            wv_reg[2] <= wv_reg[1];
            wv_reg[1] <= wv_reg[0];
            wv_reg[0] <= t1 + t2;
        end

        if (cmd.emit)
        begin
            out_reg.digest_word <= hash_reg[cmd.word_idx];
            out_reg.word_index  <= cmd.word_idx;
            out_reg.last_word   <= (cmd.word_idx == WORD_LAST);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            bitcnt_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < HASH_WORDS; i++)
            begin
                hash_reg[i] <= HASH_IV[i];
            end
        end
        else
        begin
            if (cmd.restart)
            begin
                cnt_reg    <= '0;
                bitcnt_reg <= '0;
            end
            else
            begin
                if (cmd.shift_byte)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                if (cmd.count_bits)
                begin
                    bitcnt_reg <= bitcnt_reg + BITS_PER_BYTE;
                end
            end

            if (cmd.restart)
            begin
                for (int i = 0; i < HASH_WORDS; i++)
                begin
                    hash_reg[i] <= HASH_IV[i];
                end
            end
            else if (cmd.fold)
            begin
                for (int i = 0; i < HASH_WORDS; i++)
                begin
                    hash_reg[i] <= hash_reg[i] + wv_reg[i];
                end
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (dig_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.cnt      = cnt_reg;
    assign sts.out_free = !out_valid_reg || dig_ready;
    assign dig_valid    = out_valid_reg;
    assign dig          = out_reg;

endmodule

>>> design/sha256_stream_hasher.sv
// SHA-256 stream hasher, top level: controller plus datapath.
// Depends on shs_pkg, shs_ctrl and shs_datapath.
//
// Usage:
//   msg channel (msg_valid/msg_ready/msg): one transaction per message byte
//   (action = absorb) or one finish transaction (action = finish, byte ignored).
//   dig channel (dig_valid/dig_ready/dig): eight transactions per finish, H0
//   first, word_index 0..7, last_word set on the eighth.
// Timing:
//   The 64th byte of a block starts a compression of 64 rounds plus a fold into
//   the hash words, during which msg_ready is low; the rounds run on the single
//   shared round unit, one round per cycle.
//   A finish shifts padding one byte per cycle until the block is full,
//   compresses, adds a second padded block when fewer than nine bytes were
//   free, then emits one digest word per cycle while dig_ready is high. The
//   first word is registered after the fold of the final block.
// Reset: rst_n clears the sequencer and counters and loads the initial hash.
// Stall: dig is a registered output; a low dig_ready holds the current word and
//   pauses emission. After the eighth word is registered the block is back at
//   the initial hash and takes new bytes while that word still waits.
module sha256_stream_hasher
    import shs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     msg_valid,
    output logic     msg_ready,
    input  shs_in_t  msg,
    output logic     dig_valid,
    input  logic     dig_ready,
    output shs_out_t dig
);

    shs_cmd_t cmd;
    shs_sts_t sts;

    shs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg_ready (msg_ready),
        .action    (msg.action),
        .sts       (sts),
        .cmd       (cmd)
    );

    shs_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_byte  (msg.msg_byte),
        .cmd       (cmd),
        .sts       (sts),
        .dig_valid (dig_valid),
        .dig_ready (dig_ready),
        .dig       (dig)
    );

endmodule

>>> dv/tb_sha256_stream_hasher.sv
// Self-checking testbench for sha256_stream_hasher: known digests, padding edges, backpressure.
// Depends on shs_pkg and the sha256_stream_hasher RTL; its SHA-256 digest model is its own.
module tb_sha256_stream_hasher;
    import shs_pkg::*;

    localparam int QUIET_LIMIT = 5000;   // cycles without any transaction
    localparam int N_DIRECTED  = 13;
    localparam int N_NOISE     = 20;

    localparam logic [255:0] EMPTY_DIGEST =
        256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
    localparam logic [255:0] ABC_DIGEST =
        256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

    localparam logic [31:0] IV_WORDS [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Directed stimulus: one transaction per row. Rows with known set carry a
    // published digest; the rest are checked against the digest model.
    typedef struct packed {
        shs_in_t      item;
        logic         known;
        logic [255:0] known_digest;
    } dir_row_t;

    localparam dir_row_t DIRECTED [N_DIRECTED] = '{
        {ACT_FINISH, 8'hff, 1'b1, EMPTY_DIGEST},   // empty message, byte ignored
        {ACT_ABSORB, 8'h61, 1'b0, 256'h0},         // "abc"
        {ACT_ABSORB, 8'h62, 1'b0, 256'h0},
        {ACT_ABSORB, 8'h63, 1'b0, 256'h0},
        {ACT_FINISH, 8'h00, 1'b1, ABC_DIGEST},
        {ACT_ABSORB, 8'h00, 1'b0, 256'h0},         // byte extremes and bit patterns
        {ACT_ABSORB, 8'hff, 1'b0, 256'h0},
        {ACT_ABSORB, 8'h55, 1'b0, 256'h0},
        {ACT_ABSORB, 8'haa, 1'b0, 256'h0},
        {ACT_FINISH, 8'h5a, 1'b0, 256'h0},
        {ACT_FINISH, 8'h00, 1'b1, EMPTY_DIGEST},   // finish right after finish
        {ACT_ABSORB, 8'h80, 1'b0, 256'h0},         // data byte equal to pad mark
        {ACT_FINISH, 8'ha5, 1'b0, 256'h0}
    };

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     msg_valid = 1'b0;
    logic     msg_ready;
    shs_in_t  msg = '0;
    logic     dig_valid;
    logic     dig_ready = 1'b0;
    shs_out_t dig;

    // Digest model state
    logic [31:0]  chain_h [8];
    logic [7:0]   blk_bytes [64];
    int           blk_fill;
    logic [63:0]  msg_bits;
    logic [255:0] digest_pred;

    shs_out_t digest_q [$];   // digest words still owed by the block

    int  err_cnt = 0;
    int  words_checked = 0;
    int  items_sent = 0;
    int  msgs_done = 0;
    bit  stall_burst = 1'b0;  // sender asks the receiver for one long hold-off

    sha256_stream_hasher i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg_valid (msg_valid),
        .msg_ready (msg_ready),
        .msg       (msg),
        .dig_valid (dig_valid),
        .dig_ready (dig_ready),
        .dig       (dig)
    );

    always #1 clk = ~clk;

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        logic [63:0] d;
        d = {x, x} >> n;
        return d[31:0];
    endfunction

    // One 64-round compression of blk_bytes into chain_h.
    function automatic void sha_compress();
        logic [31:0] w [16];
        logic [31:0] v [8];
        logic [31:0] wr, w2, w15, t1, t2;
        int r;
        for (r = 0; r < 16; r++)
            w[r] = {blk_bytes[4*r], blk_bytes[4*r+1], blk_bytes[4*r+2], blk_bytes[4*r+3]};
        for (r = 0; r < 8; r++)
            v[r] = chain_h[r];
        for (r = 0; r < 64; r++)
        begin
            if (r < 16)
            begin
                wr = w[r];
            end
            else
            begin
                w2  = w[(r - 2) % 16];
                w15 = w[(r - 15) % 16];
                wr  = (ror(w2, 17) ^ ror(w2, 19) ^ (w2 >> 10)) + w[(r - 7) % 16]
                    + (ror(w15, 7) ^ ror(w15, 18) ^ (w15 >> 3)) + w[r % 16];
                w[r % 16] = wr;
            end
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[r] + wr;
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (r = 0; r < 8; r++)
            chain_h[r] += v[r];
    endfunction

    // Advance the model by one transaction; returns 1 when digest_pred is fresh.
    function automatic bit sha_step(input shs_in_t it);
        int n;
        n = blk_fill;
        if (it.action == ACT_ABSORB)
        begin
            blk_bytes[n] = it.msg_byte;
            msg_bits += 64'd8;
            if (n == BLOCK_BYTES - 1)
            begin
                sha_compress();
                blk_fill = 0;
            end
            else
            begin
                blk_fill = n + 1;
            end
            return 1'b0;
        end
        blk_bytes[n] = PAD_MARK;
        n++;
        // no room for the length field: zero the tail and spend an extra block
        if (n > LEN_POS)
        begin
            while (n < BLOCK_BYTES)
            begin
                blk_bytes[n] = 8'h00;
                n++;
            end
            sha_compress();
            n = 0;
        end
        while (n < LEN_POS)
        begin
            blk_bytes[n] = 8'h00;
            n++;
        end
        for (n = 0; n < 8; n++)
            blk_bytes[LEN_POS + n] = msg_bits[63 - 8*n -: 8];
        sha_compress();
        for (n = 0; n < 8; n++)
        begin
            digest_pred[255 - 32*n -: 32] = chain_h[n];
            chain_h[n] = IV_WORDS[n];
        end
        blk_fill = 0;
        msg_bits = '0;
        return 1'b1;
    endfunction

    // Mostly short idle gaps, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(20, 60);
        return $urandom_range(0, 3);
    endfunction

    // Offer one transaction after an optional gap, hold it until accepted, then
    // run the model and queue the eight digest words a finish owes.
    task automatic offer(input shs_in_t it, input int gap, input logic known,
                         input logic [255:0] known_digest);
        logic [255:0] d;
        shs_out_t     e;
        int           i;
        if (gap > 0)
        begin
            msg_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        msg       <= it;
        msg_valid <= 1'b1;
        do @(posedge clk); while (!msg_ready);
        items_sent++;
        if (sha_step(it))
        begin
            d = known ? known_digest : digest_pred;
            for (i = 0; i < 8; i++)
            begin
                e.digest_word = d[255 - 32*i -: 32];
                e.word_index  = i[WIDX_W-1:0];
                e.last_word   = (e.word_index == WORD_LAST);
                digest_q.push_back(e);
            end
            msgs_done++;
        end
    endtask

    // Random message of len bytes plus its finish; steady means no gaps.
    task automatic send_message(input int len, input bit steady);
        shs_in_t it;
        int      i;
        for (i = 0; i <= len; i++)
        begin
            it.action   = (i == len) ? ACT_FINISH : ACT_ABSORB;
            it.msg_byte = 8'($urandom);
            offer(it, steady ? 0 : pick_gap(), 1'b0, 256'h0);
        end
    endtask

    // Stop offering and wait until every owed digest word has been taken.
    task automatic drain();
        msg_valid <= 1'b0;
        @(posedge clk);
        while (digest_q.size() != 0)
            @(posedge clk);
    endtask

    // Scoreboard: each digest transaction against the oldest owed word.
    always @(posedge clk)
    begin
        shs_out_t want;
        if (rst_n && dig_valid && dig_ready)
        begin
            if (digest_q.size() == 0)
            begin
                $error("unexpected digest transaction: digest_word %h", dig.digest_word);
                err_cnt++;
            end
            else
            begin
                want = digest_q.pop_front();
                words_checked++;
                if (dig.digest_word !== want.digest_word)
                begin
                    $error("digest_word: expected %h, actual %h",
                           want.digest_word, dig.digest_word);
                    err_cnt++;
                end
                if (dig.word_index !== want.word_index)
                begin
                    $error("word_index: expected %0d, actual %0d",
                           want.word_index, dig.word_index);
                    err_cnt++;
                end
                if (dig.last_word !== want.last_word)
                begin
                    $error("last_word: expected %b, actual %b",
                           want.last_word, dig.last_word);
                    err_cnt++;
                end
            end
        end
    end

    // Receiver: runs of ready (some long, no idling) broken by random gaps.
    // On request it holds ready low so the block fills and stalls msg.
    initial
    begin
        int run_left;
        int gap_left;
        run_left = 0;
        gap_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_burst)
            begin
                stall_burst = 1'b0;
                run_left    = 0;
                gap_left    = 400;
            end
            else if (run_left == 0 && gap_left == 0)
            begin
                run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                       : $urandom_range(1, 12);
                gap_left = pick_gap();
            end
            if (run_left > 0)
            begin
                dig_ready <= 1'b1;
                run_left--;
            end
            else
            begin
                dig_ready <= 1'b0;
                gap_left--;
            end
        end
    end

    // Watchdog: too long without any transaction on either channel.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((msg_valid && msg_ready) || (dig_valid && dig_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_sha256_stream_hasher NOT OK");
        $finish;
    end

    initial
    begin
        shs_in_t it;
        int      i;
        for (i = 0; i < 8; i++)
            chain_h[i] = IV_WORDS[i];
        for (i = 0; i < 64; i++)
            blk_bytes[i] = 8'h00;
        blk_fill = 0;
        msg_bits = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < N_DIRECTED; i++)
            offer(DIRECTED[i].item, pick_gap(), DIRECTED[i].known, DIRECTED[i].known_digest);
        drain();

        // Multi-block and padding edges: full block then finish at zero fill,
        // 56 bytes (pad mark leaves no room for length), 63 bytes (mark fills block).
        send_message(64, $urandom_range(0, 3) == 0);
        send_message(56, $urandom_range(0, 3) == 0);
        send_message(63, $urandom_range(0, 3) == 0);
        drain();

        // Long receiver hold-off while short messages keep coming back to back.
        stall_burst = 1'b1;
        repeat (6)
            send_message($urandom_range(0, 2), 1'b1);
        drain();

        // Noise: random actions, finish about one time in six.
        for (i = 0; i < N_NOISE; i++)
        begin
            it.action   = ($urandom_range(0, 5) == 0) ? ACT_FINISH : ACT_ABSORB;
            it.msg_byte = 8'($urandom);
            offer(it, pick_gap(), 1'b0, 256'h0);
        end
        drain();
        // room for a compression still running and any stray digest transaction
        repeat (150) @(posedge clk);

        $display("covered %0d msg transactions in %0d digests, %0d digest words checked",
                 items_sent, msgs_done, words_checked);
        $display("  incl. empty/abc vectors, padding overflow, full blocks, long backpressure");
        if (err_cnt == 0)
            $display("tb_sha256_stream_hasher OK");
        else
            $display("tb_sha256_stream_hasher NOT OK");
        $finish;
    end

endmodule
